/* hdl/h264nl_pkg.sv */
// Shared types and constants for the H.264 neighbour locator.
// No dependencies; used by every module in hdl/.
package h264nl_pkg;

  typedef enum logic [1:0] {
    REQ_LUMA       = 2'd0,
    REQ_CHROMA     = 2'd1,
    REQ_LUMA_BLK   = 2'd2,
    REQ_CHROMA_BLK = 2'd3
  } req_mode_t;

  localparam logic [4:0] MB_SIZE      = 5'd16;
  localparam logic [8:0] FW_RESET     = 9'd11;
  localparam logic       CFG_IDX_FW   = 1'b0;
  localparam int         DIV_BITS     = 13;
  localparam int         DIV_SPS      = 4;
  localparam int         DIV_STAGES   = (DIV_BITS + DIV_SPS - 1) / DIV_SPS;
  localparam int         DIV_IDX_W    = $clog2(DIV_BITS);

  typedef struct packed {
    req_mode_t         mode;
    logic [12:0]       curr_mb;
    logic [1:0]        block_x;
    logic [1:0]        block_y;
    logic signed [5:0] offset_x;
    logic signed [5:0] offset_y;
    logic              avail_a;
    logic              avail_b;
    logic              avail_c;
    logic              avail_d;
    logic              deblock_call;
  } req_t;

  // after macroblock wrap and block offset
  typedef struct packed {
    req_mode_t         mode;
    logic [12:0]       curr;
    logic signed [6:0] xn;
    logic signed [6:0] yn;
    logic              avail_a;
    logic              avail_b;
    logic              avail_c;
    logic              avail_d;
    logic              deblock_call;
  } loc_t;

  typedef struct packed {
    logic signed [13:0] addr;
    logic               avail;
    logic               pic_ok;
    logic               luma;
    logic               scale;
    logic [3:0]         lx;
    logic [3:0]         ly;
    logic [12:0]        dividend;
  } nbr_t;

  typedef struct packed {
    nbr_t        nbr;
    logic [12:0] row;
    logic [8:0]  col;
  } div_res_t;

  typedef struct packed {
    logic signed [13:0] neighbour_addr;
    logic               available;
    logic [3:0]         local_x;
    logic [3:0]         local_y;
    logic [11:0]        pic_x;
    logic [16:0]        pic_y;
  } res_t;

endpackage

/* hdl/h264nl_front.sv */
// Front end: macroblock wrap, block offset, region decode, local wrap.
// Two register stages; depends on h264nl_pkg.
module h264nl_front #(
  parameter int CHROMA_MB_WIDTH  = 8,
  parameter int CHROMA_MB_HEIGHT = 8,
  parameter int MAX_MBS          = 8192
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  h264nl_pkg::req_t  in_req,
  input  logic [8:0]        frame_w,
  output logic              out_valid,
  input  logic              out_ready,
  output h264nl_pkg::nbr_t  out_nbr
);

  localparam int MB_QB = $clog2(8191 / MAX_MBS + 1);
  localparam int WOFF  = 16 * CHROMA_MB_WIDTH;
  localparam int HOFF  = 16 * CHROMA_MB_HEIGHT;
  localparam int WQB   = $clog2((63 + WOFF) / CHROMA_MB_WIDTH + 1);
  localparam int HQB   = $clog2((63 + HOFF) / CHROMA_MB_HEIGHT + 1);

  logic             a_v_r, b_v_r;
  logic             a_rdy, b_rdy;
  h264nl_pkg::loc_t a_r, a_nxt;
  h264nl_pkg::nbr_t b_r, b_nxt;

  assign b_rdy     = !b_v_r || out_ready;
  assign a_rdy     = !a_v_r || b_rdy;
  assign in_ready  = a_rdy;
  assign out_valid = b_v_r;
  assign out_nbr   = b_r;

  // stage A
  always_comb begin
    logic [12:0]       c;
    logic              blk;
    logic signed [6:0] ax;
    logic signed [6:0] ay;
    c   = in_req.curr_mb;
    for (int k = MB_QB - 1; k >= 0; k--) begin
      if ({19'd0, c} >= (MAX_MBS << k)) begin
        c = c - 13'(MAX_MBS << k);
      end
    end
    blk = (in_req.mode == h264nl_pkg::REQ_LUMA_BLK) ||
          (in_req.mode == h264nl_pkg::REQ_CHROMA_BLK);
    ax  = blk ? $signed({3'b000, in_req.block_x, 2'b00}) : 7'sd0;
    ay  = blk ? $signed({3'b000, in_req.block_y, 2'b00}) : 7'sd0;
    a_nxt.mode         = in_req.mode;
    a_nxt.curr         = c;
    a_nxt.xn           = 7'(in_req.offset_x) + ax;
    a_nxt.yn           = 7'(in_req.offset_y) + ay;
    a_nxt.avail_a      = in_req.avail_a;
    a_nxt.avail_b      = in_req.avail_b;
    a_nxt.avail_c      = in_req.avail_c;
    a_nxt.avail_d      = in_req.avail_d;
    a_nxt.deblock_call = in_req.deblock_call;
  end

  // stage B
  always_comb begin
    logic               luma;
    logic               blk;
    logic [4:0]         maxw;
    logic [4:0]         maxh;
    logic               xneg, yneg, xin, yin;
    logic [13:0]        cur;
    logic [13:0]        w;
    logic signed [13:0] addr;
    logic               av;
    logic               calc;
    logic [9:0]         vx, vy;
    logic [3:0]         wx, wy;
    luma = (a_r.mode == h264nl_pkg::REQ_LUMA) || (a_r.mode == h264nl_pkg::REQ_LUMA_BLK);
    blk  = (a_r.mode == h264nl_pkg::REQ_LUMA_BLK) ||
           (a_r.mode == h264nl_pkg::REQ_CHROMA_BLK);
    maxw = luma ? h264nl_pkg::MB_SIZE : 5'(CHROMA_MB_WIDTH);
    maxh = luma ? h264nl_pkg::MB_SIZE : 5'(CHROMA_MB_HEIGHT);
    xneg = a_r.xn[6];
    yneg = a_r.yn[6];
    xin  = a_r.xn < $signed({2'b00, maxw});
    yin  = a_r.yn < $signed({2'b00, maxh});
    cur  = {1'b0, a_r.curr};
    w    = {5'd0, frame_w};
    addr = 14'sd0;
    av   = 1'b0;
    if (xneg && yneg) begin
      addr = $signed(cur - w - 14'd1);
      av   = a_r.avail_d;
    end else if (xneg && yin) begin
      addr = $signed(cur - 14'd1);
      av   = a_r.avail_a;
    end else if (xin && yneg) begin
      addr = $signed(cur - w);
      av   = a_r.avail_b;
    end else if (xin && yin) begin
      addr = $signed(cur);
      av   = 1'b1;
    end else if (yneg) begin
      addr = $signed(cur - w + 14'd1);
      av   = a_r.avail_c;
    end
    calc = av || a_r.deblock_call;

    vx = {{3{a_r.xn[6]}}, a_r.xn} + 10'(WOFF);
    for (int k = WQB - 1; k >= 0; k--) begin
      if ({22'd0, vx} >= (CHROMA_MB_WIDTH << k)) begin
        vx = vx - 10'(CHROMA_MB_WIDTH << k);
      end
    end
    vy = {{3{a_r.yn[6]}}, a_r.yn} + 10'(HOFF);
    for (int k = HQB - 1; k >= 0; k--) begin
      if ({22'd0, vy} >= (CHROMA_MB_HEIGHT << k)) begin
        vy = vy - 10'(CHROMA_MB_HEIGHT << k);
      end
    end
    wx = luma ? a_r.xn[3:0] : vx[3:0];
    wy = luma ? a_r.yn[3:0] : vy[3:0];

    b_nxt.addr     = addr;
    b_nxt.avail    = av;
    b_nxt.pic_ok   = calc && !addr[13];
    b_nxt.luma     = luma;
    b_nxt.scale    = blk && av;
    b_nxt.lx       = calc ? wx : 4'd0;
    b_nxt.ly       = calc ? wy : 4'd0;
    b_nxt.dividend = addr[13] ? 13'd0 : addr[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_v_r <= in_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_r <= a_nxt;
    end
    if (b_rdy && a_v_r) begin
      b_r <= b_nxt;
    end
  end

endmodule

/* hdl/h264nl_div.sv */
// Pipelined restoring divider: neighbour address by frame width in MBs.
// Gives row and column, carries the item alongside; depends on h264nl_pkg.
module h264nl_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  h264nl_pkg::nbr_t     in_nbr,
  input  logic [8:0]           frame_w,
  output logic                 out_valid,
  input  logic                 out_ready,
  output h264nl_pkg::div_res_t out_res
);

  localparam int NS = h264nl_pkg::DIV_STAGES;

  logic [NS:0]      vld;
  logic [NS:0]      rdy;
  h264nl_pkg::nbr_t pl [NS+1];
  logic [12:0]      qt [NS+1];
  logic [8:0]       rm [NS+1];

  assign vld[0]   = in_valid;
  assign pl[0]    = in_nbr;
  assign qt[0]    = 13'd0;
  assign rm[0]    = 9'd0;
  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic             v_r;
    h264nl_pkg::nbr_t pl_r;
    logic [12:0]      q_r, q_nxt;
    logic [8:0]       rm_r, rm_nxt;

    assign rdy[s]    = !v_r || rdy[s+1];
    assign vld[s+1]  = v_r;
    assign pl[s+1]   = pl_r;
    assign qt[s+1]   = q_r;
    assign rm[s+1]   = rm_r;

    always_comb begin
      logic [8:0] r;
      logic [9:0] sh;
      int         k;
      r     = rm[s];
      q_nxt = qt[s];
      for (int j = 0; j < h264nl_pkg::DIV_SPS; j++) begin
        k = h264nl_pkg::DIV_BITS - 1 - (s * h264nl_pkg::DIV_SPS + j);
        if (k >= 0) begin
          sh = {r, pl[s].dividend[k[h264nl_pkg::DIV_IDX_W-1:0]]};
          if (sh >= {1'b0, frame_w}) begin
            sh = sh - {1'b0, frame_w};
            q_nxt[k[h264nl_pkg::DIV_IDX_W-1:0]] = 1'b1;
          end
          r = sh[8:0];
        end
      end
      rm_nxt = r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (rdy[s]) begin
        v_r <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vld[s]) begin
        pl_r <= pl[s];
        q_r  <= q_nxt;
        rm_r <= rm_nxt;
      end
    end
  end

  assign out_valid   = vld[NS];
  assign out_res.nbr = pl[NS];
  assign out_res.row = qt[NS];
  assign out_res.col = rm[NS];

endmodule

/* hdl/h264nl_pos.sv */
// Output stage: picture position from row and column, 4x4 scaling.
// One register stage that is the result register; depends on h264nl_pkg.
module h264nl_pos #(
  parameter int CHROMA_MB_WIDTH  = 8,
  parameter int CHROMA_MB_HEIGHT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  h264nl_pkg::div_res_t in_res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output h264nl_pkg::res_t     out_res
);

  logic             v_r;
  h264nl_pkg::res_t res_r, res_nxt;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_res   = res_r;

  always_comb begin
    logic [4:0]  maxw;
    logic [4:0]  maxh;
    logic [13:0] px;
    logic [18:0] py;
    logic [3:0]  lx, ly;
    maxw = in_res.nbr.luma ? h264nl_pkg::MB_SIZE : 5'(CHROMA_MB_WIDTH);
    maxh = in_res.nbr.luma ? h264nl_pkg::MB_SIZE : 5'(CHROMA_MB_HEIGHT);
    px   = 14'(in_res.col) * 14'(maxw) + 14'(in_res.nbr.lx);
    py   = 19'(in_res.row) * 19'(maxh) + 19'(in_res.nbr.ly);
    lx   = in_res.nbr.lx;
    ly   = in_res.nbr.ly;
    if (!in_res.nbr.pic_ok) begin
      px = 14'd0;
      py = 19'd0;
    end
    if (in_res.nbr.scale) begin
      px = px >> 2;
      py = py >> 2;
      lx = lx >> 2;
      ly = ly >> 2;
    end
    res_nxt.neighbour_addr = in_res.nbr.addr;
    res_nxt.available      = in_res.nbr.avail;
    res_nxt.local_x        = lx;
    res_nxt.local_y        = ly;
    res_nxt.pic_x          = px[11:0];
    res_nxt.pic_y          = py[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* hdl/h264_neighbour_locate_top.sv */
// Top level of the H.264 neighbour locator: config register and pipeline.
// Depends on h264nl_pkg, h264nl_front, h264nl_div, h264nl_pos.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | request fields, one port each
//   out_    | output    | out_valid/out_ready  | neighbour fields, one port each
//   cfg_    | input     | APB write/read       | frame_width_mbs at byte 0
//
// One item per cycle while no stage stalls; register stages: 2 front stages, 4 divider
// stages of 4 quotient bits, 1 output register. The divider sets the depth.
// Synchronous reset clears the valid bits and sets the width to 11.
// Each stage holds under a stall and takes a new item when it empties.
module h264_neighbour_locate_top #(
  parameter int CHROMA_MB_WIDTH  = 8,
  parameter int CHROMA_MB_HEIGHT = 8,
  parameter int MAX_MBS          = 8192
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [12:0]        in_curr_mb,
  input  logic [1:0]         in_block_x,
  input  logic [1:0]         in_block_y,
  input  logic signed [5:0]  in_offset_x,
  input  logic signed [5:0]  in_offset_y,
  input  logic               in_avail_a,
  input  logic               in_avail_b,
  input  logic               in_avail_c,
  input  logic               in_avail_d,
  input  logic               in_deblock_call,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_neighbour_addr,
  output logic               out_available,
  output logic [3:0]         out_local_x,
  output logic [3:0]         out_local_y,
  output logic [11:0]        out_pic_x,
  output logic [16:0]        out_pic_y,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [8:0]                 fw_r;
  logic [8:0]                 fw_eff;
  h264nl_pkg::req_t           req;
  h264nl_pkg::nbr_t           f_nbr;
  h264nl_pkg::div_res_t       d_res;
  h264nl_pkg::res_t           res;
  logic                       f_valid, f_ready, d_valid, d_ready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == h264nl_pkg::CFG_IDX_FW) ? {23'd0, fw_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= h264nl_pkg::FW_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == h264nl_pkg::CFG_IDX_FW) begin
      fw_r <= cfg_pwdata[8:0];
    end
  end

  // zero width behaves as one
  assign fw_eff = (fw_r == 9'd0) ? 9'd1 : fw_r;

  assign req.mode         = h264nl_pkg::req_mode_t'(in_req_type);
  assign req.curr_mb      = in_curr_mb;
  assign req.block_x      = in_block_x;
  assign req.block_y      = in_block_y;
  assign req.offset_x     = in_offset_x;
  assign req.offset_y     = in_offset_y;
  assign req.avail_a      = in_avail_a;
  assign req.avail_b      = in_avail_b;
  assign req.avail_c      = in_avail_c;
  assign req.avail_d      = in_avail_d;
  assign req.deblock_call = in_deblock_call;

  h264nl_front #(
    .CHROMA_MB_WIDTH  (CHROMA_MB_WIDTH),
    .CHROMA_MB_HEIGHT (CHROMA_MB_HEIGHT),
    .MAX_MBS          (MAX_MBS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (req),
    .frame_w   (fw_eff),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_nbr   (f_nbr)
  );

  h264nl_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_nbr    (f_nbr),
    .frame_w   (fw_eff),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_res   (d_res)
  );

  h264nl_pos #(
    .CHROMA_MB_WIDTH  (CHROMA_MB_WIDTH),
    .CHROMA_MB_HEIGHT (CHROMA_MB_HEIGHT)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_res    (d_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_neighbour_addr = res.neighbour_addr;
  assign out_available      = res.available;
  assign out_local_x        = res.local_x;
  assign out_local_y        = res.local_y;
  assign out_pic_x          = res.pic_x;
  assign out_pic_y          = res.pic_y;

endmodule

/* sim/tb_h264_neighbour_locate_top.sv */
// Self-checking testbench for h264_neighbour_locate_top: neighbour lookups
// checked against a built-in predictor under several widths and idle mixes.
// Depends on h264nl_pkg and the RTL under hdl/.
`timescale 1ns / 100ps

module tb_h264_neighbour_locate_top;

  localparam int CHROMA_W    = 8;
  localparam int CHROMA_H    = 8;
  localparam int MB_COUNT    = 8192;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 12;
  localparam logic [2:0] FW_ADDR = {h264nl_pkg::CFG_IDX_FW, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_req_type = '0;
  logic [12:0]        in_curr_mb = '0;
  logic [1:0]         in_block_x = '0;
  logic [1:0]         in_block_y = '0;
  logic signed [5:0]  in_offset_x = '0;
  logic signed [5:0]  in_offset_y = '0;
  logic               in_avail_a = 1'b0;
  logic               in_avail_b = 1'b0;
  logic               in_avail_c = 1'b0;
  logic               in_avail_d = 1'b0;
  logic               in_deblock_call = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [13:0] out_neighbour_addr;
  logic               out_available;
  logic [3:0]         out_local_x;
  logic [3:0]         out_local_y;
  logic [11:0]        out_pic_x;
  logic [16:0]        out_pic_y;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  h264nl_pkg::req_t pending_q[$];
  h264nl_pkg::res_t expected_q[$];
  h264nl_pkg::req_t drive_req = '0;
  logic [8:0]       width_shadow = h264nl_pkg::FW_RESET;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  bit               hold_sender = 1'b0;
  int               errors = 0;
  int               accepted = 0;
  int               checked = 0;
  int               cycles = 0;

  h264_neighbour_locate_top #(
    .CHROMA_MB_WIDTH (CHROMA_W),
    .CHROMA_MB_HEIGHT(CHROMA_H),
    .MAX_MBS         (MB_COUNT)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_curr_mb        (in_curr_mb),
    .in_block_x        (in_block_x),
    .in_block_y        (in_block_y),
    .in_offset_x       (in_offset_x),
    .in_offset_y       (in_offset_y),
    .in_avail_a        (in_avail_a),
    .in_avail_b        (in_avail_b),
    .in_avail_c        (in_avail_c),
    .in_avail_d        (in_avail_d),
    .in_deblock_call   (in_deblock_call),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_neighbour_addr(out_neighbour_addr),
    .out_available     (out_available),
    .out_local_x       (out_local_x),
    .out_local_y       (out_local_y),
    .out_pic_x         (out_pic_x),
    .out_pic_y         (out_pic_y),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int wrap_pos(int v, int m);
    int r;
    r = v % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic h264nl_pkg::res_t locate_neighbour(h264nl_pkg::req_t r, logic [8:0] fw);
    int               w, cur, xn, yn, max_w, max_h, addr, lx, ly, px, py;
    bit               luma, blocks, avail;
    h264nl_pkg::res_t res;
    luma   = (r.mode == h264nl_pkg::REQ_LUMA) || (r.mode == h264nl_pkg::REQ_LUMA_BLK);
    blocks = (r.mode == h264nl_pkg::REQ_LUMA_BLK) || (r.mode == h264nl_pkg::REQ_CHROMA_BLK);
    w      = (fw == 0) ? 1 : int'(fw);
    cur    = int'(r.curr_mb) % MB_COUNT;
    xn     = $signed(r.offset_x);
    yn     = $signed(r.offset_y);
    max_w  = luma ? int'(h264nl_pkg::MB_SIZE) : CHROMA_W;
    max_h  = luma ? int'(h264nl_pkg::MB_SIZE) : CHROMA_H;
    addr   = 0;
    avail  = 1'b0;
    lx = 0; ly = 0; px = 0; py = 0;
    if (blocks) begin
      xn += int'(r.block_x) * 4;
      yn += int'(r.block_y) * 4;
    end
    if (xn < 0 && yn < 0) begin
      addr = cur - w - 1; avail = r.avail_d;
    end else if (xn < 0 && yn < max_h) begin
      addr = cur - 1;     avail = r.avail_a;
    end else if (xn < max_w && yn < 0) begin
      addr = cur - w;     avail = r.avail_b;
    end else if (xn < max_w && yn < max_h) begin
      addr = cur;         avail = 1'b1;
    end else if (yn < 0) begin
      addr = cur - w + 1; avail = r.avail_c;
    end
    if (avail || r.deblock_call) begin
      lx = wrap_pos(xn + max_w, max_w);
      ly = wrap_pos(yn + max_h, max_h);
      if (addr >= 0) begin
        px = (addr % w) * max_w + lx;
        py = (addr / w) * max_h + ly;
      end
      if (blocks && avail) begin
        lx >>= 2; ly >>= 2; px >>= 2; py >>= 2;
      end
    end
    res.neighbour_addr = addr[13:0];
    res.available      = avail;
    res.local_x        = lx[3:0];
    res.local_y        = ly[3:0];
    res.pic_x          = px[11:0];
    res.pic_y          = py[16:0];
    return res;
  endfunction

  function automatic h264nl_pkg::req_t make_req(h264nl_pkg::req_mode_t m, int cur, int bx,
                                                int by, int ox, int oy,
                                                bit [3:0] abcd, bit db);
    h264nl_pkg::req_t r;
    r.mode         = m;
    r.curr_mb      = 13'(cur);
    r.block_x      = 2'(bx);
    r.block_y      = 2'(by);
    r.offset_x     = 6'(ox);
    r.offset_y     = 6'(oy);
    r.avail_a      = abcd[3];
    r.avail_b      = abcd[2];
    r.avail_c      = abcd[1];
    r.avail_d      = abcd[0];
    r.deblock_call = db;
    return r;
  endfunction

  // mostly plausible lookups, the rest fully random fields
  function automatic h264nl_pkg::req_t random_req();
    h264nl_pkg::req_t r;
    int               ext, w;
    r.mode         = h264nl_pkg::req_mode_t'($urandom_range(3));
    r.block_x      = 2'($urandom_range(3));
    r.block_y      = 2'($urandom_range(3));
    r.avail_a      = 1'($urandom_range(1));
    r.avail_b      = 1'($urandom_range(1));
    r.avail_c      = 1'($urandom_range(1));
    r.avail_d      = 1'($urandom_range(1));
    r.deblock_call = 1'($urandom_range(1));
    if ($urandom_range(99) < 75) begin
      ext = (r.mode == h264nl_pkg::REQ_LUMA || r.mode == h264nl_pkg::REQ_LUMA_BLK) ?
            int'(h264nl_pkg::MB_SIZE) : CHROMA_W;
      w   = (width_shadow == 0) ? 1 : int'(width_shadow);
      if (r.mode == h264nl_pkg::REQ_LUMA_BLK || r.mode == h264nl_pkg::REQ_CHROMA_BLK) begin
        if (r.mode == h264nl_pkg::REQ_CHROMA_BLK) begin
          r.block_x = 2'($urandom_range(1));
          r.block_y = 2'($urandom_range(1));
        end
        r.offset_x = 6'(int'($urandom_range(5)) - 1);
        r.offset_y = 6'(int'($urandom_range(5)) - 1);
      end else begin
        r.offset_x = 6'(int'($urandom_range(ext + 1)) - 1);
        r.offset_y = 6'(int'($urandom_range(ext + 1)) - 1);
      end
      if ($urandom_range(1))
        r.curr_mb = 13'($urandom_range((2 * w + 2 > 8191) ? 8191 : 2 * w + 2));
      else
        r.curr_mb = 13'($urandom_range(8191));
    end else begin
      r.curr_mb  = 13'($urandom_range(8191));
      r.offset_x = 6'($urandom_range(63));
      r.offset_y = 6'($urandom_range(63));
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] act_v);
    if (act_v !== exp_v) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_q.push_back(locate_neighbour(drive_req, width_shadow));
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() > 0 && !hold_sender && $urandom_range(99) >= send_idle_pct) begin
          drive_req = pending_q.pop_front();
          in_valid        <= 1'b1;
          in_req_type     <= drive_req.mode;
          in_curr_mb      <= drive_req.curr_mb;
          in_block_x      <= drive_req.block_x;
          in_block_y      <= drive_req.block_y;
          in_offset_x     <= drive_req.offset_x;
          in_offset_y     <= drive_req.offset_y;
          in_avail_a      <= drive_req.avail_a;
          in_avail_b      <= drive_req.avail_b;
          in_avail_c      <= drive_req.avail_c;
          in_avail_d      <= drive_req.avail_d;
          in_deblock_call <= drive_req.deblock_call;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    h264nl_pkg::res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (errors < 40)
            $display("%0t: unexpected result, expected none, got addr %0h",
                     $time, out_neighbour_addr);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("neighbour_addr", 17'(want.neighbour_addr), 17'(out_neighbour_addr));
          check_field("available", 17'(want.available), 17'(out_available));
          check_field("local_x", 17'(want.local_x), 17'(out_local_x));
          check_field("local_y", 17'(want.local_y), 17'(out_local_y));
          check_field("pic_x", 17'(want.pic_x), 17'(out_pic_x));
          check_field("pic_y", want.pic_y, out_pic_y);
          checked++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_width(logic [8:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= FW_ADDR;
    cfg_pwdata  <= {23'b0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    width_shadow = value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (cfg_prdata !== {23'b0, value}) begin
      $display("%0t: frame width readback, expected %0h, got %0h",
               $time, {23'b0, value}, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int width, bit do_write, int idle_pct, int stall_pct,
                           int n_items, bit mid_pause);
    wait_drain();
    if (do_write) write_width(9'(width));
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) pending_q.push_back(random_req());
    if (mid_pause) begin
      do @(negedge clk);
      while (pending_q.size() > n_items / 2);
      hold_sender = 1'b1;
      do @(negedge clk);
      while (in_valid || expected_q.size() != 0);
      repeat (5) @(negedge clk);
      hold_sender = 1'b0;
    end
    do @(negedge clk);
    while (pending_q.size() != 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // region corners, negative addresses, block units, deblock on unavailable
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 0, 0, 0, -1, -1, 4'b1111, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 12, 0, 0, -1, -1, 4'b0001, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 25, 0, 0, -1, 5, 4'b1000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 25, 0, 0, 7, -1, 4'b0100, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 25, 0, 0, 15, 15, 4'b0000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 25, 0, 0, 16, -1, 4'b0010, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 25, 0, 0, 16, 3, 4'b1111, 1'b1));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 25, 0, 0, 16, 16, 4'b1111, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_CHROMA, 30, 0, 0, -1, 7, 4'b1000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_CHROMA, 30, 0, 0, 8, -1, 4'b0010, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_CHROMA, 30, 0, 0, 7, 7, 4'b0000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_CHROMA, 30, 0, 0, 8, 8, 4'b0000, 1'b1));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA_BLK, 40, 3, 3, 3, 3, 4'b0000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA_BLK, 40, 0, 2, -1, 0, 4'b1000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA_BLK, 40, 3, 0, 4, -1, 4'b0000, 1'b1));
    pending_q.push_back(make_req(h264nl_pkg::REQ_CHROMA_BLK, 40, 1, 1, -1, -1, 4'b0001,
                                 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_CHROMA_BLK, 40, 3, 3, 0, 0, 4'b1111, 1'b1));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 8191, 0, 0, 0, 0, 4'b0000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 8191, 0, 0, -1, 0, 4'b0000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 8191, 0, 0, -32, -32, 4'b0001, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 0, 0, 0, 31, 31, 4'b0000, 1'b1));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA, 0, 0, 0, -1, 0, 4'b1000, 1'b0));
    pending_q.push_back(make_req(h264nl_pkg::REQ_CHROMA_BLK, 8191, 3, 3, 31, -32, 4'b1111,
                                 1'b1));
    pending_q.push_back(make_req(h264nl_pkg::REQ_LUMA_BLK, 5, 0, 0, -32, 31, 4'b1111, 1'b1));

    run_phase(11, 1'b0, 0, 0, 400, 1'b0);
    run_phase(1, 1'b1, 66, 0, 400, 1'b1);
    run_phase(256, 1'b1, 0, 66, 400, 1'b0);
    run_phase(0, 1'b1, 10, 10, 200, 1'b0);
    run_phase(511, 1'b1, 10, 10, 150, 1'b0);
    run_phase(int'($urandom_range(255)) + 1, 1'b1, 10, 10, 200, 1'b0);
    wait_drain();

    $display("Covered %0d lookups over all four request modes and every region,", accepted);
    $display("frame widths 0, 1, 11, 256, 511 and one random; %0d results checked", checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* h264_neighbour_locate_top.f */
hdl/h264nl_pkg.sv
hdl/h264nl_front.sv
hdl/h264nl_div.sv
hdl/h264nl_pos.sv
hdl/h264_neighbour_locate_top.sv
sim/tb_h264_neighbour_locate_top.sv
